// ----- hdl/ipr_pkg.sv -----
// Shared types and constants for the integer pixel replication scaler.
// Used by the front end, the queue, the back end and the top level.
`timescale 1ns / 1ps
`default_nettype none

package ipr_pkg;

  localparam int PIX_W   = 8;
  localparam int DROW_W  = 8;
  localparam int DCOL_W  = 7;
  localparam int SW_W    = 5;
  localparam int SH_W    = 6;
  localparam int SCALE_W = 4;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  // register byte offsets
  localparam logic [ADDR_W-1:0] REG_SRC_WIDTH    = 4'h0;
  localparam logic [ADDR_W-1:0] REG_SRC_HEIGHT   = 4'h4;
  localparam logic [ADDR_W-1:0] REG_WIDTH_SCALE  = 4'h8;
  localparam logic [ADDR_W-1:0] REG_HEIGHT_SCALE = 4'hC;

  // effective (clamped) configuration
  typedef struct packed {
    logic [SW_W-1:0]    width;
    logic [SH_W-1:0]    height;
    logic [SCALE_W-1:0] wscale;
    logic [SCALE_W-1:0] hscale;
  } cfg_t;

  // one classified source pixel waiting for replication
  typedef struct packed {
    logic [PIX_W-1:0]  pixel;
    logic [DROW_W-1:0] base_row;
    logic [DCOL_W-1:0] base_col;
    logic              last_pixel;
  } entry_t;

endpackage

`default_nettype wire

// ----- hdl/ipr_front.sv -----
// Front end: accepts source pixels, tracks the source position and
// computes each cell's destination origin. Depends on ipr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ipr_front #(
  parameter int MAX_SRC_WIDTH  = 16,
  parameter int MAX_SRC_HEIGHT = 32
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire ipr_pkg::cfg_t   cfg,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [ipr_pkg::PIX_W-1:0] in_pixel,
  input  wire logic            q_full,
  output logic                 q_push,
  output ipr_pkg::entry_t      q_entry
);

  localparam int COL_W = (MAX_SRC_WIDTH > 1) ? $clog2(MAX_SRC_WIDTH) : 1;
  localparam int ROW_W = (MAX_SRC_HEIGHT > 1) ? $clog2(MAX_SRC_HEIGHT) : 1;

  logic [COL_W-1:0] col_r, col_nxt, col_cur;
  logic [ROW_W-1:0] row_r, row_nxt, row_cur;
  logic             col_wrap;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  always_comb begin
    // drop stale positions left beyond a shrunk frame
    col_cur = (ipr_pkg::SW_W'(col_r) >= cfg.width)  ? '0 : col_r;
    row_cur = (ipr_pkg::SH_W'(row_r) >= cfg.height) ? '0 : row_r;

    col_wrap = (ipr_pkg::SW_W'(col_cur) + 1'b1) >= cfg.width;
    col_nxt  = col_wrap ? '0 : col_cur + 1'b1;
    row_nxt  = row_cur;
    if (col_wrap) begin
      row_nxt = ((ipr_pkg::SH_W'(row_cur) + 1'b1) >= cfg.height) ? '0 : row_cur + 1'b1;
    end

    q_entry.pixel      = in_pixel;
    q_entry.base_row   = ipr_pkg::DROW_W'(row_cur) * ipr_pkg::DROW_W'(cfg.hscale);
    q_entry.base_col   = ipr_pkg::DCOL_W'(col_cur) * ipr_pkg::DCOL_W'(cfg.wscale);
    q_entry.last_pixel = (ipr_pkg::SH_W'(row_cur) == cfg.height - 1'b1) &&
                         (ipr_pkg::SW_W'(col_cur) == cfg.width - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (q_push) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/ipr_fifo.sv -----
// Two-entry queue of classified pixels between front end and back end.
// Depends on ipr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ipr_fifo (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire ipr_pkg::entry_t push_entry,
  output logic                 full,
  input  wire logic            pop,
  output logic                 empty,
  output ipr_pkg::entry_t      head
);

  ipr_pkg::entry_t slot_r [2];
  logic            wptr_r, rptr_r;
  logic [1:0]      count_r, count_nxt;

  assign full  = count_r == 2'd2;
  assign empty = count_r == 2'd0;
  assign head  = slot_r[rptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !(pop && !empty)) count_nxt = count_r + 1'b1;
    else if (!push && pop && !empty) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wptr_r] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= 1'b0;
      rptr_r  <= 1'b0;
      count_r <= 2'd0;
    end else begin
      if (push)           wptr_r <= ~wptr_r;
      if (pop && !empty)  rptr_r <= ~rptr_r;
      count_r <= count_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/ipr_back.sv -----
// Back end: walks each queued cell row by row, column by column, and
// drives one destination write per cycle while the output is taken, through an output register.
// Depends on ipr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ipr_back #(
  parameter int MAX_SCALE = 8
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire ipr_pkg::cfg_t   cfg,
  input  wire logic            q_empty,
  input  wire ipr_pkg::entry_t q_head,
  output logic                 q_pop,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [ipr_pkg::DROW_W-1:0] out_dest_row,
  output logic [ipr_pkg::DCOL_W-1:0] out_dest_col,
  output logic [ipr_pkg::PIX_W-1:0]  out_pixel,
  output logic                 out_cell_done,
  output logic                 out_frame_done
);

  localparam int SC_W = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;

  logic [SC_W-1:0] cr_r, cr_nxt, cc_r, cc_nxt;
  logic            last_col, last_row, slot_free, fire;

  logic                       valid_r;
  logic [ipr_pkg::DROW_W-1:0] row_r;
  logic [ipr_pkg::DCOL_W-1:0] col_r;
  logic [ipr_pkg::PIX_W-1:0]  pix_r;
  logic                       cell_r, frame_r;

  assign slot_free = !valid_r || out_ready;
  assign fire      = slot_free && !q_empty;
  assign last_col  = ipr_pkg::SCALE_W'(cc_r) == cfg.wscale - 1'b1;
  assign last_row  = ipr_pkg::SCALE_W'(cr_r) == cfg.hscale - 1'b1;
  assign q_pop     = fire && last_col && last_row;

  always_comb begin
    cc_nxt = cc_r;
    cr_nxt = cr_r;
    if (fire) begin
      if (last_col) begin
        cc_nxt = '0;
        cr_nxt = last_row ? '0 : cr_r + 1'b1;
      end else begin
        cc_nxt = cc_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cc_r    <= '0;
      cr_r    <= '0;
      valid_r <= 1'b0;
    end else begin
      cc_r <= cc_nxt;
      cr_r <= cr_nxt;
      if (slot_free) valid_r <= !q_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      row_r   <= q_head.base_row + ipr_pkg::DROW_W'(cr_r);
      col_r   <= q_head.base_col + ipr_pkg::DCOL_W'(cc_r);
      pix_r   <= q_head.pixel;
      cell_r  <= last_col && last_row;
      frame_r <= last_col && last_row && q_head.last_pixel;
    end
  end

  assign out_valid      = valid_r;
  assign out_dest_row   = row_r;
  assign out_dest_col   = col_r;
  assign out_pixel      = pix_r;
  assign out_cell_done  = cell_r;
  assign out_frame_done = frame_r;

  a_frame_implies_cell: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && frame_r |-> cell_r)
    else $error("frame_done without cell_done");

  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ipr_pkg::SCALE_W'(cc_r) < cfg.wscale)
    else $error("cell column counter out of range");

  a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ipr_pkg::SCALE_W'(cr_r) < cfg.hscale)
    else $error("cell row counter out of range");

  a_pop_on_cell_end: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> valid_r && cell_r)
    else $error("queue popped without a cell-done write");

endmodule

`default_nettype wire

// ----- hdl/integer_pixel_replication_scaler.sv -----
// Integer pixel replication scaler. Each accepted source pixel produces
// height_scale * width_scale destination writes, one per clock while the
// output is taken, counted out by the back end's cell row and column
// counters. The front end accepts a new pixel every cycle while its
// two-entry queue has room, and the result register is reloaded in the
// same cycle its write is taken, so writes leave back to back.
// Registers at byte offsets 0, 4, 8, 12: src_width, src_height,
// width_scale, height_scale; zero acts as one and large values saturate.
// Depends on ipr_pkg, ipr_front, ipr_fifo, ipr_back.
`timescale 1ns / 1ps
`default_nettype none

module integer_pixel_replication_scaler #(
  parameter int MAX_SRC_WIDTH  = 16,
  parameter int MAX_SRC_HEIGHT = 32,
  parameter int MAX_SCALE      = 8
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_psel,
  input  wire logic                        cfg_penable,
  input  wire logic                        cfg_pwrite,
  input  wire logic [ipr_pkg::ADDR_W-1:0]  cfg_paddr,
  input  wire logic [ipr_pkg::DATA_W-1:0]  cfg_pwdata,
  output logic [ipr_pkg::DATA_W-1:0]       cfg_prdata,
  output logic                             cfg_pready,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [ipr_pkg::PIX_W-1:0]   in_pixel_in,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [ipr_pkg::DROW_W-1:0]       out_dest_row,
  output logic [ipr_pkg::DCOL_W-1:0]       out_dest_col,
  output logic [ipr_pkg::PIX_W-1:0]        out_pixel_out,
  output logic                             out_cell_done,
  output logic                             out_frame_done
);

  logic [ipr_pkg::SW_W-1:0]    src_width_r;
  logic [ipr_pkg::SH_W-1:0]    src_height_r;
  logic [ipr_pkg::SCALE_W-1:0] width_scale_r, height_scale_r;
  logic                        wr_en;
  logic [ipr_pkg::ADDR_W-1:0]  reg_addr;
  ipr_pkg::cfg_t               cfg;

  ipr_pkg::entry_t q_entry, q_head;
  logic            q_push, q_pop, q_full, q_empty;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_addr   = {cfg_paddr[ipr_pkg::ADDR_W-1:2], 2'b00};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r    <= ipr_pkg::SW_W'(10);
      src_height_r   <= ipr_pkg::SH_W'(20);
      width_scale_r  <= ipr_pkg::SCALE_W'(1);
      height_scale_r <= ipr_pkg::SCALE_W'(1);
    end else if (wr_en) begin
      case (reg_addr)
        ipr_pkg::REG_SRC_WIDTH:    src_width_r    <= cfg_pwdata[ipr_pkg::SW_W-1:0];
        ipr_pkg::REG_SRC_HEIGHT:   src_height_r   <= cfg_pwdata[ipr_pkg::SH_W-1:0];
        ipr_pkg::REG_WIDTH_SCALE:  width_scale_r  <= cfg_pwdata[ipr_pkg::SCALE_W-1:0];
        ipr_pkg::REG_HEIGHT_SCALE: height_scale_r <= cfg_pwdata[ipr_pkg::SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_addr)
      ipr_pkg::REG_SRC_WIDTH:    cfg_prdata = ipr_pkg::DATA_W'(src_width_r);
      ipr_pkg::REG_SRC_HEIGHT:   cfg_prdata = ipr_pkg::DATA_W'(src_height_r);
      ipr_pkg::REG_WIDTH_SCALE:  cfg_prdata = ipr_pkg::DATA_W'(width_scale_r);
      ipr_pkg::REG_HEIGHT_SCALE: cfg_prdata = ipr_pkg::DATA_W'(height_scale_r);
      default:                   cfg_prdata = '0;
    endcase
  end

  // clamp each register into its legal range
  always_comb begin
    cfg.width = src_width_r;
    if (src_width_r == '0) cfg.width = ipr_pkg::SW_W'(1);
    else if (src_width_r > ipr_pkg::SW_W'(MAX_SRC_WIDTH))
      cfg.width = ipr_pkg::SW_W'(MAX_SRC_WIDTH);

    cfg.height = src_height_r;
    if (src_height_r == '0) cfg.height = ipr_pkg::SH_W'(1);
    else if (src_height_r > ipr_pkg::SH_W'(MAX_SRC_HEIGHT))
      cfg.height = ipr_pkg::SH_W'(MAX_SRC_HEIGHT);

    cfg.wscale = width_scale_r;
    if (width_scale_r == '0) cfg.wscale = ipr_pkg::SCALE_W'(1);
    else if (width_scale_r > ipr_pkg::SCALE_W'(MAX_SCALE))
      cfg.wscale = ipr_pkg::SCALE_W'(MAX_SCALE);

    cfg.hscale = height_scale_r;
    if (height_scale_r == '0) cfg.hscale = ipr_pkg::SCALE_W'(1);
    else if (height_scale_r > ipr_pkg::SCALE_W'(MAX_SCALE))
      cfg.hscale = ipr_pkg::SCALE_W'(MAX_SCALE);
  end

  ipr_front #(
    .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
    .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_pixel (in_pixel_in),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (q_entry)
  );

  ipr_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .empty      (q_empty),
    .head       (q_head)
  );

  ipr_back #(
    .MAX_SCALE (MAX_SCALE)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .q_empty        (q_empty),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_dest_row   (out_dest_row),
    .out_dest_col   (out_dest_col),
    .out_pixel      (out_pixel_out),
    .out_cell_done  (out_cell_done),
    .out_frame_done (out_frame_done)
  );

endmodule

`default_nettype wire

// ----- test/testbench.sv -----
// Self-checking testbench for integer_pixel_replication_scaler: directed and random
// pixel streams with register setup, checked write by write against a local predictor.
// Depends on ipr_pkg and the scaler RTL.
`timescale 1ns / 1ps

module testbench;

  localparam int MAX_SRC_WIDTH  = 16;
  localparam int MAX_SRC_HEIGHT = 32;
  localparam int MAX_SCALE      = 8;
  localparam int STALL_LIMIT    = 4000;
  localparam int HOLD_CYCLES    = 400;

  typedef struct {
    logic [ipr_pkg::DROW_W-1:0] dest_row;
    logic [ipr_pkg::DCOL_W-1:0] dest_col;
    logic [ipr_pkg::PIX_W-1:0]  pixel;
    logic                       cell_done;
    logic                       frame_done;
  } dest_write_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       cfg_psel = 1'b0;
  logic                       cfg_penable = 1'b0;
  logic                       cfg_pwrite = 1'b0;
  logic [ipr_pkg::ADDR_W-1:0] cfg_paddr = '0;
  logic [ipr_pkg::DATA_W-1:0] cfg_pwdata = '0;
  logic [ipr_pkg::DATA_W-1:0] cfg_prdata;
  logic                       cfg_pready;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [ipr_pkg::PIX_W-1:0]  in_pixel_in = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [ipr_pkg::DROW_W-1:0] out_dest_row;
  logic [ipr_pkg::DCOL_W-1:0] out_dest_col;
  logic [ipr_pkg::PIX_W-1:0]  out_pixel_out;
  logic                       out_cell_done;
  logic                       out_frame_done;

  // register shadows as written, before clamping
  logic [ipr_pkg::SW_W-1:0]    reg_src_width = 5'd10;
  logic [ipr_pkg::SH_W-1:0]    reg_src_height = 6'd20;
  logic [ipr_pkg::SCALE_W-1:0] reg_width_scale = 4'd1;
  logic [ipr_pkg::SCALE_W-1:0] reg_height_scale = 4'd1;
  // source position of the next pixel
  logic [4:0] src_row = '0;
  logic [3:0] src_col = '0;

  dest_write_t pending_writes[$];
  dest_write_t head_write;
  int unsigned pixels_sent = 0;
  int unsigned mismatches = 0;
  int unsigned send_idle_pct = 9;
  int unsigned recv_idle_pct = 59;
  int unsigned hold_requests = 0;
  int unsigned holds_served = 0;
  int unsigned hold_left = 0;
  int unsigned stall_cycles = 0;

  integer_pixel_replication_scaler i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_psel      (cfg_psel),
    .cfg_penable   (cfg_penable),
    .cfg_pwrite    (cfg_pwrite),
    .cfg_paddr     (cfg_paddr),
    .cfg_pwdata    (cfg_pwdata),
    .cfg_prdata    (cfg_prdata),
    .cfg_pready    (cfg_pready),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_pixel_in   (in_pixel_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_dest_row  (out_dest_row),
    .out_dest_col  (out_dest_col),
    .out_pixel_out (out_pixel_out),
    .out_cell_done (out_cell_done),
    .out_frame_done(out_frame_done)
  );

  always #5 clk = ~clk;

  function automatic int clamp_reg(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // Expand one source pixel into its cell of destination writes.
  function automatic void replicate_pixel(logic [ipr_pkg::PIX_W-1:0] pix);
    int w, h, ws, hs, row, col;
    logic last_pixel;
    dest_write_t wr;
    w   = clamp_reg(32'(reg_src_width), MAX_SRC_WIDTH);
    h   = clamp_reg(32'(reg_src_height), MAX_SRC_HEIGHT);
    ws  = clamp_reg(32'(reg_width_scale), MAX_SCALE);
    hs  = clamp_reg(32'(reg_height_scale), MAX_SCALE);
    row = 32'(src_row);
    col = 32'(src_col);
    // a shrunk frame restarts counters that fell outside it
    if (col >= w) col = 0;
    if (row >= h) row = 0;
    last_pixel = (row == h - 1) && (col == w - 1);
    for (int cr = 0; cr < hs; cr++) begin
      for (int cc = 0; cc < ws; cc++) begin
        wr.dest_row   = ipr_pkg::DROW_W'(row * hs + cr);
        wr.dest_col   = ipr_pkg::DCOL_W'(col * ws + cc);
        wr.pixel      = pix;
        wr.cell_done  = (cr == hs - 1) && (cc == ws - 1);
        wr.frame_done = wr.cell_done && last_pixel;
        pending_writes.push_back(wr);
      end
    end
    col++;
    if (col >= w) begin
      col = 0;
      row++;
      if (row >= h) row = 0;
    end
    src_col = 4'(col);
    src_row = 5'(row);
  endfunction

  function automatic void check_field(string field, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endfunction

  function automatic logic [ipr_pkg::DATA_W-1:0] pad_upper(logic [ipr_pkg::DATA_W-1:0] v,
                                                           int unsigned bits);
    logic [ipr_pkg::DATA_W-1:0] mask;
    mask = (32'h1 << bits) - 1;
    return ($urandom() & ~mask) | (v & mask);
  endfunction

  // Called at a falling edge; returns at a falling edge with valid still high.
  task automatic send_pixel(input logic [ipr_pkg::PIX_W-1:0] pix);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_pixel_in <= pix;
    do @(posedge clk); while (!in_ready);
    replicate_pixel(pix);
    pixels_sent++;
    @(negedge clk);
  endtask

  task automatic send_random_pixels(input int unsigned count);
    repeat (count) send_pixel($urandom_range(255));
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_writes.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [ipr_pkg::ADDR_W-1:0] addr,
                           input logic [ipr_pkg::DATA_W-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (addr)
      ipr_pkg::REG_SRC_WIDTH:    reg_src_width    = data[ipr_pkg::SW_W-1:0];
      ipr_pkg::REG_SRC_HEIGHT:   reg_src_height   = data[ipr_pkg::SH_W-1:0];
      ipr_pkg::REG_WIDTH_SCALE:  reg_width_scale  = data[ipr_pkg::SCALE_W-1:0];
      ipr_pkg::REG_HEIGHT_SCALE: reg_height_scale = data[ipr_pkg::SCALE_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic write_config(input logic [ipr_pkg::DATA_W-1:0] w,
                              input logic [ipr_pkg::DATA_W-1:0] h,
                              input logic [ipr_pkg::DATA_W-1:0] ws,
                              input logic [ipr_pkg::DATA_W-1:0] hs);
    write_reg(ipr_pkg::REG_SRC_WIDTH, w);
    write_reg(ipr_pkg::REG_SRC_HEIGHT, h);
    write_reg(ipr_pkg::REG_WIDTH_SCALE, ws);
    write_reg(ipr_pkg::REG_HEIGHT_SCALE, hs);
  endtask

  task automatic test_reset_defaults();
    send_pixel(8'h00);
    send_pixel(8'hFF);
    send_pixel(8'h55);
    send_pixel(8'hAA);
    send_pixel(8'h01);
    send_pixel(8'hFE);
    in_valid <= 1'b0;
    wait_drained();
  endtask

  task automatic test_register_limits();
    // zero in the field, noise above it: acts as a 1x1 frame at 1x1 scale
    write_config(32'hFFFF_FFE0, 32'h0000_0040, 32'hABCD_EF00, 32'h8000_0010);
    send_pixel(8'h00);
    send_pixel(8'hFF);
    send_pixel(8'h3C);
    in_valid <= 1'b0;
    wait_drained();
    // above range saturates to the largest frame and scale
    write_config(32'd31, 32'd63, 32'd15, 32'd15);
    send_pixel(8'hFF);
    send_pixel(8'h00);
    in_valid <= 1'b0;
    wait_drained();
  endtask

  task automatic test_shrink_counters();
    write_config(32'd8, 32'd4, 32'd3, 32'd2);
    send_random_pixels(11);
    wait_drained();
    // leave the position outside the new frame
    write_reg(ipr_pkg::REG_SRC_WIDTH, 32'd2);
    write_reg(ipr_pkg::REG_SRC_HEIGHT, 32'd1);
    send_random_pixels(3);
    wait_drained();
  endtask

  task automatic pick_config();
    int unsigned sel;
    logic [ipr_pkg::DATA_W-1:0] w, h, ws, hs;
    sel = $urandom_range(99);
    if (sel < 70) begin
      w  = $urandom_range(1, 4);
      h  = $urandom_range(1, 3);
      ws = $urandom_range(1, 4);
      hs = $urandom_range(1, 4);
    end else if (sel < 88) begin
      w  = $urandom_range(31);
      h  = $urandom_range(63);
      ws = $urandom_range(15);
      hs = $urandom_range(15);
    end else begin
      w  = $urandom_range(1) ? MAX_SRC_WIDTH : 1;
      h  = $urandom_range(1) ? MAX_SRC_HEIGHT : 1;
      ws = $urandom_range(1) ? MAX_SCALE : 1;
      hs = $urandom_range(1) ? MAX_SCALE : 1;
    end
    write_config(pad_upper(w, ipr_pkg::SW_W), pad_upper(h, ipr_pkg::SH_W),
                 pad_upper(ws, ipr_pkg::SCALE_W), pad_upper(hs, ipr_pkg::SCALE_W));
  endtask

  task automatic test_random_frames();
    int frame_px, cell_px;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 9;  recv_idle_pct = 59; end
        1: begin send_idle_pct = 59; recv_idle_pct = 9;  end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      while (pixels_sent < 25 + 110 * (phase + 1)) begin
        pick_config();
        frame_px = clamp_reg(32'(reg_src_width), MAX_SRC_WIDTH) *
                   clamp_reg(32'(reg_src_height), MAX_SRC_HEIGHT);
        cell_px  = clamp_reg(32'(reg_width_scale), MAX_SCALE) *
                   clamp_reg(32'(reg_height_scale), MAX_SCALE);
        // up to three frames when small, one to six pixels when big
        if (frame_px <= 12 && cell_px <= 16)
          send_random_pixels($urandom_range(1, 3 * frame_px));
        else
          send_random_pixels($urandom_range(1, 6));
        wait_drained();
      end
    end
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_config(32'd3, 32'd2, 32'd2, 32'd2);
    hold_requests++;
    send_random_pixels(12);
    wait_drained();
  endtask

  // Result side: random stalls, plus a long hold-off on request.
  always @(negedge clk) begin
    if (holds_served != hold_requests) begin
      holds_served <= holds_served + 1;
      hold_left    <= HOLD_CYCLES;
      out_ready    <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_writes.size() == 0) begin
        $error("unexpected write: row %0d col %0d pixel %0d",
               out_dest_row, out_dest_col, out_pixel_out);
        mismatches++;
      end else begin
        head_write = pending_writes.pop_front();
        check_field("dest_row", head_write.dest_row, out_dest_row);
        check_field("dest_col", 8'(head_write.dest_col), 8'(out_dest_col));
        check_field("pixel_out", head_write.pixel, out_pixel_out);
        check_field("cell_done", 8'(head_write.cell_done), 8'(out_cell_done));
        check_field("frame_done", 8'(head_write.frame_done), 8'(out_frame_done));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL integer_pixel_replication_scaler");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_register_limits();
    test_shrink_counters();
    test_random_frames();
    test_backpressure();
    repeat (20) @(negedge clk);
    if (mismatches == 0 && pending_writes.size() == 0) begin
      $display("PASS integer_pixel_replication_scaler");
    end else begin
      $display("FAIL integer_pixel_replication_scaler");
    end
    $finish;
  end

endmodule
